>>> rtl/core/positional_list_store_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the positional list store
// Shared property forms, clocked on clk and disabled during rst.
// ----------------------------------------------------------------------------
`ifndef POSITIONAL_LIST_STORE_ASSERT_SVH
`define POSITIONAL_LIST_STORE_ASSERT_SVH

// same-cycle implication
`define PLS_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("positional_list_store: same-cycle check failed");

// next-cycle implication
`define PLS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("positional_list_store: next-cycle check failed");

`endif

>>> rtl/core/pls_pkg.sv
// ----------------------------------------------------------------------------
// pls_pkg
// Types and codes shared by the list store top level and its cells.
// ----------------------------------------------------------------------------
package pls_pkg;

  // requested action of one input beat
  typedef enum logic [2:0] {
    ACT_INS_FRONT = 3'd0,
    ACT_INS_BACK  = 3'd1,
    ACT_INS_POS   = 3'd2,
    ACT_DEL_FRONT = 3'd3,
    ACT_DEL_BACK  = 3'd4,
    ACT_DEL_POS   = 3'd5,
    ACT_SHOW_FWD  = 3'd6,
    ACT_SHOW_BWD  = 3'd7
  } action_t;

  // result status codes
  typedef enum logic [1:0] {
    STS_OK     = 2'd0,
    STS_EMPTY  = 2'd1,
    STS_BADPOS = 2'd2,
    STS_FULL   = 2'd3
  } status_t;

  // command broadcast to every cell
  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_INS,
    CELL_DEL,
    CELL_ROT_FWD,
    CELL_ROT_BWD
  } cell_op_t;

  // control sequencer states
  typedef enum logic {
    ST_IDLE,
    ST_SHOW
  } state_t;

  localparam int DATA_W = 32;

endpackage

>>> rtl/core/positional_list_store.sv
// ----------------------------------------------------------------------------
// positional_list_store
// Bounded ordered list of signed words held in a chain of shifting cells.
// ----------------------------------------------------------------------------
// Usage:
//   Input beat: action, value and position are taken at a rising edge with
//   start high and busy low. Results come one per cycle on item_value,
//   status and last, each marked by done for exactly one cycle.
//   Edits (insert/delete front, back, at 1-based position) shift all cells
//   at once in the accept cycle; their single status beat shows on done in
//   the next cycle, and busy stays low, so edits run one per cycle.
//   Read-out (forward or backward) rotates the occupied cells through the
//   head (forward) or the tail (backward), one entry per cycle: busy is high
//   for the whole rotation and each result shows in the cycle after its step,
//   the final one with last set. An empty list gives one "list empty" beat.
//   The rotation by entry_count steps returns the chain to its order.
//   A full list, a bad position or an empty list is flagged in status and
//   leaves the contents unchanged.
//   Reset (rst, synchronous) empties the list and drops done and busy;
//   cell contents are not cleared. The receiver cannot stall: every beat on
//   done is taken in its cycle.
// ----------------------------------------------------------------------------
module positional_list_store #(
  parameter int CAPACITY = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic [2:0]                          action,
  input  logic signed [pls_pkg::DATA_W-1:0]   value,
  input  logic [4:0]                          position,
  output logic                                done,
  output logic signed [pls_pkg::DATA_W-1:0]   item_value,
  output logic [1:0]                          status,
  output logic                                last
);
  import pls_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int IW = $clog2(CAPACITY);
  localparam int PW = ((CW > 5) ? CW : 5) + 1;
  localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

  state_t   state, state_next;
  logic [CW-1:0] count, count_next;
  logic [CW-1:0] remaining;
  logic          dir_bwd;

  logic          accept;
  cell_op_t      cell_op;
  logic [CW-1:0] cell_idx;
  logic          show_go;
  logic          res_fire;
  logic signed [DATA_W-1:0] res_value;
  status_t       res_status;
  logic          res_last;

  logic signed [DATA_W-1:0] cell_q [CAPACITY];
  logic signed [DATA_W-1:0] tail_value;
  logic signed [DATA_W-1:0] wrap_value;
  logic [PW-1:0] pos_x;
  logic [PW-1:0] cnt_x;
  logic [IW-1:0] tail_idx;

  assign busy   = (state == ST_SHOW);
  assign accept = start && !busy;
  assign pos_x  = PW'(position);
  assign cnt_x  = PW'(count);

  // tail entry for backward read-out
  assign tail_idx   = IW'(count - CW'(1));
  assign tail_value = cell_q[tail_idx];
  assign wrap_value = (cell_op == CELL_ROT_FWD) ? cell_q[0] : tail_value;

  // chain of cells
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic signed [DATA_W-1:0] left_v;
    logic signed [DATA_W-1:0] right_v;
    if (g == 0) begin : g_first
      assign left_v = value;
    end else begin : g_mid_l
      assign left_v = cell_q[g-1];
    end
    if (g == CAPACITY - 1) begin : g_end
      assign right_v = cell_q[g];
    end else begin : g_mid_r
      assign right_v = cell_q[g+1];
    end
    pls_cell #(
      .CW    (CW),
      .INDEX (g)
    ) u_cell (
      .clk         (clk),
      .op          (cell_op),
      .idx         (cell_idx),
      .count       (count),
      .ld_value    (value),
      .left_value  (left_v),
      .right_value (right_v),
      .wrap_value  (wrap_value),
      .value       (cell_q[g])
    );
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (show_go) state_next = ST_SHOW;
      ST_SHOW: if (remaining == CW'(1)) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // decode and cell commands
  always_comb begin
    cell_op    = CELL_HOLD;
    cell_idx   = '0;
    count_next = count;
    show_go    = 1'b0;
    res_fire   = 1'b0;
    res_value  = '0;
    res_status = STS_OK;
    res_last   = 1'b1;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          res_fire = 1'b1;
          case (action_t'(action))
            ACT_INS_FRONT, ACT_INS_BACK: begin
              if (count == CAP_C) begin
                res_status = STS_FULL;
              end else begin
                cell_op    = CELL_INS;
                cell_idx   = (action_t'(action) == ACT_INS_BACK) ? count : '0;
                count_next = count + CW'(1);
              end
            end
            ACT_INS_POS: begin
              if (pos_x == '0 || pos_x > cnt_x + PW'(1)) begin
                res_status = STS_BADPOS;
              end else if (count == CAP_C) begin
                res_status = STS_FULL;
              end else begin
                cell_op    = CELL_INS;
                cell_idx   = CW'(pos_x - PW'(1));
                count_next = count + CW'(1);
              end
            end
            ACT_DEL_FRONT, ACT_DEL_BACK: begin
              if (count == '0) begin
                res_status = STS_EMPTY;
              end else begin
                cell_op    = CELL_DEL;
                cell_idx   = (action_t'(action) == ACT_DEL_BACK) ? count - CW'(1) : '0;
                count_next = count - CW'(1);
              end
            end
            ACT_DEL_POS: begin
              if (count == '0) begin
                res_status = STS_EMPTY;
              end else if (pos_x == '0 || pos_x > cnt_x) begin
                res_status = STS_BADPOS;
              end else begin
                cell_op    = CELL_DEL;
                cell_idx   = CW'(pos_x - PW'(1));
                count_next = count - CW'(1);
              end
            end
            default: begin
              // read-out: empty answers at once, else start the rotation
              if (count == '0) begin
                res_status = STS_EMPTY;
              end else begin
                res_fire = 1'b0;
                show_go  = 1'b1;
              end
            end
          endcase
        end
      end
      ST_SHOW: begin
        cell_op   = dir_bwd ? CELL_ROT_BWD : CELL_ROT_FWD;
        res_fire  = 1'b1;
        res_value = dir_bwd ? tail_value : cell_q[0];
        res_last  = (remaining == CW'(1));
      end
      default: begin
        cell_op = CELL_HOLD;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      remaining <= '0;
      dir_bwd   <= 1'b0;
      done      <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      done  <= res_fire;
      if (show_go) begin
        remaining <= count;
        dir_bwd   <= (action_t'(action) == ACT_SHOW_BWD);
      end else if (state == ST_SHOW) begin
        remaining <= remaining - CW'(1);
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (res_fire) begin
      item_value <= res_value;
      status     <= res_status;
      last       <= res_last;
    end
  end

  // checks
`include "positional_list_store_assert.svh"

  `PLS_ASSERT_NEXT(a_readout_contig, done && !last, done)
  `PLS_ASSERT_NEXT(a_edit_one_beat, accept && (action < ACT_SHOW_FWD), done && last)
  `PLS_ASSERT_NOW(a_error_is_last, done && (status != STS_OK), last)
  `PLS_ASSERT_NOW(a_show_nonempty, busy, (count != '0) && (remaining != '0))

endmodule

>>> rtl/core/pls_cell.sv
// ----------------------------------------------------------------------------
// pls_cell
// One storage cell of the list chain: picks its next value from its left or
// right neighbor, the insert word or the wrap bus, by the broadcast command.
// ----------------------------------------------------------------------------
module pls_cell #(
  parameter int CW    = 5,
  parameter int INDEX = 0
) (
  input  logic                           clk,
  input  pls_pkg::cell_op_t              op,
  input  logic [CW-1:0]                  idx,
  input  logic [CW-1:0]                  count,
  input  logic signed [pls_pkg::DATA_W-1:0] ld_value,
  input  logic signed [pls_pkg::DATA_W-1:0] left_value,
  input  logic signed [pls_pkg::DATA_W-1:0] right_value,
  input  logic signed [pls_pkg::DATA_W-1:0] wrap_value,
  output logic signed [pls_pkg::DATA_W-1:0] value
);
  import pls_pkg::*;

  localparam logic [CW:0] MY  = (CW+1)'(INDEX);
  localparam logic [CW:0] MY1 = (CW+1)'(INDEX + 1);

  logic signed [DATA_W-1:0] value_next;
  logic [CW:0]              idx_x;
  logic [CW:0]              cnt_x;

  assign idx_x = {1'b0, idx};
  assign cnt_x = {1'b0, count};

  // next-value select
  always_comb begin
    value_next = value;
    case (op)
      CELL_INS: begin
        if (MY > idx_x) value_next = left_value;
        else if (MY == idx_x) value_next = ld_value;
      end
      CELL_DEL: begin
        if (MY >= idx_x) value_next = right_value;
      end
      CELL_ROT_FWD: begin
        if (MY1 < cnt_x) value_next = right_value;
        else if (MY1 == cnt_x) value_next = wrap_value;
      end
      CELL_ROT_BWD: begin
        if (MY == '0) value_next = wrap_value;
        else if (MY < cnt_x) value_next = left_value;
      end
      default: value_next = value;
    endcase
  end

  // storage, no reset on payload
  always_ff @(posedge clk) begin
    value <= value_next;
  end

endmodule
